// ===== design/rtgi_pkg.sv =====
// Shared constants for the rotor thrust gain interpolator: grid sizes, index widths,
// Q16.16 gain limits, command and register codes, and divider widths.
// Used by rtgi_div and rotor_thrust_gain_interpolator; depends on nothing.
package rtgi_pkg;

  localparam int HEIGHT_POINTS = 8;
  localparam int SPEED_POINTS  = 8;
  localparam int TABLE_SIZE    = HEIGHT_POINTS * SPEED_POINTS;
  localparam int HIDX_W        = $clog2(HEIGHT_POINTS);
  localparam int SIDX_W        = $clog2(SPEED_POINTS);
  localparam int TIDX_W        = $clog2(TABLE_SIZE);
  localparam int MAX_POINTS    = (HEIGHT_POINTS > SPEED_POINTS) ? HEIGHT_POINTS : SPEED_POINTS;
  localparam int SCAN_W        = $clog2(MAX_POINTS + 1);

  // Q16.16 constants.
  localparam logic [17:0] Q_ONE   = 18'd65536;
  localparam logic [17:0] G_MIN   = 18'd58982;
  localparam logic [17:0] G_MAX   = 18'd91750;
  localparam logic [17:0] G_WATER = 18'd45875;
  localparam logic [30:0] W_LIM   = 31'd1073741824;

  // Commands carried in tuser of the input word.
  localparam logic [2:0] CMD_LOAD_HEIGHT = 3'd0;
  localparam logic [2:0] CMD_LOAD_SPEED  = 3'd1;
  localparam logic [2:0] CMD_LOAD_THRUST = 3'd2;
  localparam logic [2:0] CMD_LOAD_TORQUE = 3'd3;
  localparam logic [2:0] CMD_COMPUTE     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_BLADE_RADIUS    = 3'd0;
  localparam logic [2:0] REG_MAX_ROTOR_SPEED = 3'd1;
  localparam logic [2:0] REG_THRUST_CONSTANT = 3'd2;
  localparam logic [2:0] REG_TORQUE_CONSTANT = 3'd3;
  localparam logic [2:0] REG_SPIN_DIRECTION  = 3'd4;
  localparam logic [2:0] REG_SLOWDOWN_FACTOR = 3'd5;
  localparam logic [2:0] REG_TABLE_VALID     = 3'd6;

  // Divider operand widths.
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 104;

endpackage

// ===== design/rotor_thrust_gain_interpolator.sv =====
// Rotor thrust gain interpolator top level: grid and gain memories, the compute
// sequencer, one shared multiplier and one shared divider (rtgi_div).
// Depends on rtgi_pkg and rtgi_div.
//
//  channel   signals                               role
//  s_axis    tvalid tready tdata[103:0] tuser[2:0]  load or compute word in
//  m_axis    tvalid tready tdata[103:0] tuser[0:0]  result word out
//  cfg       valid ready index[2:0] data[31:0]      register writes, always ready
//
// A load or unknown word passes through the acknowledge state to the output
// register, and the next word can be taken once the sequencer is back in idle. A
// compute word runs longer with tables in use than with gains fixed; each divide for
// the height ratio, the speed ratio and both interpolation weights yields 48
// quotient bits. Reset is synchronous; it clears the sequencer and the output valid
// and sets the configuration registers to their defaults; grid and table memories
// hold garbage until written. The input is taken only while the sequencer is idle,
// and a finished result waits in the output register while the next word is taken.
module rotor_thrust_gain_interpolator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: entry_index[5:0], load_value[37:6], joint_velocity[69:38],
  // rotor_height[101:70], zero fill[103:102]
  input  logic [rtgi_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: thrust[31:0], torque[63:32], thrust_gain[81:64], torque_gain[99:82],
  // is_underwater[100], zero fill[103:101]
  output logic [rtgi_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tuser: was_load[0]
  output logic [0:0]                           m_axis_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [31:0]                          cfg_data
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_ACK  = 5'd1;
  localparam logic [4:0] ST_RV   = 5'd2;
  localparam logic [4:0] ST_RV2  = 5'd3;
  localparam logic [4:0] ST_HR   = 5'd4;
  localparam logic [4:0] ST_HRW  = 5'd5;
  localparam logic [4:0] ST_SR   = 5'd6;
  localparam logic [4:0] ST_SRW  = 5'd7;
  localparam logic [4:0] ST_SCAN = 5'd8;
  localparam logic [4:0] ST_NB0  = 5'd9;
  localparam logic [4:0] ST_NB1  = 5'd10;
  localparam logic [4:0] ST_NB2  = 5'd11;
  localparam logic [4:0] ST_WT   = 5'd12;
  localparam logic [4:0] ST_WTW  = 5'd13;
  localparam logic [4:0] ST_TRD  = 5'd14;
  localparam logic [4:0] ST_LM   = 5'd15;
  localparam logic [4:0] ST_LA   = 5'd16;
  localparam logic [4:0] ST_SQ   = 5'd17;
  localparam logic [4:0] ST_SQ2  = 5'd18;
  localparam logic [4:0] ST_K    = 5'd19;
  localparam logic [4:0] ST_K2   = 5'd20;
  localparam logic [4:0] ST_M    = 5'd21;
  localparam logic [4:0] ST_M2   = 5'd22;
  localparam logic [4:0] ST_DONE = 5'd23;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic hi_same;
    hi_same = (x[65:31] == '0) || (x[65:31] == '1);
    if (hi_same) return x[31:0];
    return x[65] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  // Configuration registers.
  logic [30:0]        blade_radius;
  logic [30:0]        max_rotor_speed;
  logic signed [31:0] thrust_constant;
  logic signed [31:0] torque_constant;
  logic signed [1:0]  spin_direction;
  logic [30:0]        slowdown_factor;
  logic               table_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blade_radius    <= 31'd65536;
      max_rotor_speed <= 31'd65536;
      thrust_constant <= '0;
      torque_constant <= '0;
      spin_direction  <= 2'sd1;
      slowdown_factor <= 31'd655360;
      table_valid     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtgi_pkg::REG_BLADE_RADIUS:    blade_radius    <= cfg_data[30:0];
        rtgi_pkg::REG_MAX_ROTOR_SPEED: max_rotor_speed <= cfg_data[30:0];
        rtgi_pkg::REG_THRUST_CONSTANT: thrust_constant <= cfg_data;
        rtgi_pkg::REG_TORQUE_CONSTANT: torque_constant <= cfg_data;
        rtgi_pkg::REG_SPIN_DIRECTION:  spin_direction  <= cfg_data[1:0];
        rtgi_pkg::REG_SLOWDOWN_FACTOR: slowdown_factor <= cfg_data[30:0];
        rtgi_pkg::REG_TABLE_VALID:     table_valid     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input word fields.
  logic [2:0]         in_cmd;
  logic [5:0]         in_idx;
  logic signed [31:0] in_load;
  logic               in_acc;

  assign in_cmd  = s_axis_tuser;
  assign in_idx  = s_axis_tdata[5:0];
  assign in_load = s_axis_tdata[37:6];

  logic [4:0] st;
  assign s_axis_tready = (st == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Grid and gain memories. Loads write them only while the sequencer is idle and
  // the sequencer reads them only while busy, so accesses never overlap.
  logic signed [31:0] height_grid [rtgi_pkg::HEIGHT_POINTS];
  logic signed [31:0] speed_grid  [rtgi_pkg::SPEED_POINTS];
  logic signed [31:0] thrust_tab  [rtgi_pkg::TABLE_SIZE];
  logic signed [31:0] torque_tab  [rtgi_pkg::TABLE_SIZE];

  logic [rtgi_pkg::HIDX_W-1:0] hg_addr;
  logic [rtgi_pkg::SIDX_W-1:0] sg_addr;
  logic [rtgi_pkg::TIDX_W-1:0] tab_addr;
  logic signed [31:0]          hg_q, sg_q, tt_q, tq_q;
  logic                        hg_we, sg_we, tt_we, tq_we;

  assign hg_we = in_acc && in_cmd == rtgi_pkg::CMD_LOAD_HEIGHT
                 && int'(in_idx) < rtgi_pkg::HEIGHT_POINTS;
  assign sg_we = in_acc && in_cmd == rtgi_pkg::CMD_LOAD_SPEED
                 && int'(in_idx) < rtgi_pkg::SPEED_POINTS;
  assign tt_we = in_acc && in_cmd == rtgi_pkg::CMD_LOAD_THRUST
                 && int'(in_idx) < rtgi_pkg::TABLE_SIZE;
  assign tq_we = in_acc && in_cmd == rtgi_pkg::CMD_LOAD_TORQUE
                 && int'(in_idx) < rtgi_pkg::TABLE_SIZE;

  always_ff @(posedge clk) begin
    if (hg_we) height_grid[rtgi_pkg::HIDX_W'(in_idx)] <= in_load;
    hg_q <= height_grid[hg_addr];
  end

  always_ff @(posedge clk) begin
    if (sg_we) speed_grid[rtgi_pkg::SIDX_W'(in_idx)] <= in_load;
    sg_q <= speed_grid[sg_addr];
  end

  always_ff @(posedge clk) begin
    if (tt_we) thrust_tab[rtgi_pkg::TIDX_W'(in_idx)] <= in_load;
    tt_q <= thrust_tab[tab_addr];
  end

  always_ff @(posedge clk) begin
    if (tq_we) torque_tab[rtgi_pkg::TIDX_W'(in_idx)] <= in_load;
    tq_q <= torque_tab[tab_addr];
  end

  // Working registers of the compute sequence.
  logic [2:0]                  cmd_r;
  logic signed [31:0]          jv_r, h_r;
  logic signed [31:0]          rv;
  logic                        uw;
  logic [16:0]                 hr, sr;
  logic                        gsel, wsel, osel, wneg;
  logic [rtgi_pkg::SCAN_W-1:0] sc, chk_idx, fidx;
  logic                        chk, found;
  logic [rtgi_pkg::HIDX_W-1:0] ki;
  logic [rtgi_pkg::SIDX_W-1:0] kj;
  logic signed [31:0]          gh0, gh1, gs0, gs1;
  logic signed [31:0]          wt, wu;
  logic [2:0]                  tc;
  logic signed [31:0]          tf [4];
  logic signed [31:0]          qf [4];
  logic [1:0]                  lsub;
  logic                        lgain;
  logic signed [31:0]          la, lb;
  logic [17:0]                 gt, gq;
  logic signed [31:0]          sq, kk;
  logic signed [31:0]          thrust_r, torque_r;
  logic signed [65:0]          prod;

  // Output register.
  logic signed [31:0] o_thrust, o_torque;
  logic [17:0]        o_tg, o_qg;
  logic               o_uw, o_load;

  assign m_axis_tdata = {3'b000, o_uw, o_qg, o_tg, o_torque, o_thrust};
  assign m_axis_tuser = o_load;

  // Grid search: the cell is the first point above the value, clamped to 1..n-1.
  logic [16:0]                 x_scan;
  logic signed [31:0]          grid_q;
  logic [rtgi_pkg::SCAN_W-1:0] n_sel, k_raw, k_cell;
  logic                        scan_hit, scan_last;

  always_comb begin
    x_scan    = gsel ? sr : hr;
    grid_q    = gsel ? sg_q : hg_q;
    n_sel     = gsel ? rtgi_pkg::SCAN_W'(rtgi_pkg::SPEED_POINTS)
                     : rtgi_pkg::SCAN_W'(rtgi_pkg::HEIGHT_POINTS);
    scan_hit  = chk && !found && (grid_q > $signed({15'b0, x_scan}));
    scan_last = chk && (chk_idx == n_sel - rtgi_pkg::SCAN_W'(1));
    k_raw     = found ? fidx : (scan_hit ? chk_idx : n_sel);
    if (k_raw == '0) begin
      k_cell = rtgi_pkg::SCAN_W'(1);
    end else if (k_raw >= n_sel) begin
      k_cell = n_sel - rtgi_pkg::SCAN_W'(1);
    end else begin
      k_cell = k_raw;
    end
  end

  // Interpolation weight operands for the height (wsel 0) or speed (wsel 1) axis.
  logic [16:0]        wx;
  logic signed [31:0] wlo, whi;
  logic signed [32:0] wd, wn, wd_abs, wn_abs;

  always_comb begin
    wx     = wsel ? sr : hr;
    wlo    = wsel ? gs0 : gh0;
    whi    = wsel ? gs1 : gh1;
    wd     = {whi[31], whi} - {wlo[31], wlo};
    wn     = $signed({16'b0, wx}) - {wlo[31], wlo};
    wd_abs = wd[32] ? -wd : wd;
    wn_abs = wn[32] ? -wn : wn;
  end

  // Magnitudes and bypass tests for the two ratios.
  logic        hr_bypass;
  logic [32:0] rv_abs;

  assign hr_bypass = uw || blade_radius == '0
                     || ({h_r[31], h_r} >= $signed({2'b00, blade_radius}));
  assign rv_abs    = rv[31] ? -{rv[31], rv} : {rv[31], rv};

  // Shared divider.
  logic                                div_start, div_busy, div_done;
  logic [rtgi_pkg::DIV_NUM_W-1:0]      div_num, div_quot;
  logic [rtgi_pkg::DIV_DEN_W-1:0]      div_den;
  logic [30:0]                         wmag;
  logic signed [31:0]                  wval;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (st)
      ST_HR: begin
        div_start = !hr_bypass;
        div_num   = {h_r, 16'b0};
        div_den   = {2'b00, blade_radius};
      end
      ST_SR: begin
        div_start = max_rotor_speed != '0;
        div_num   = {rv_abs[31:0], 16'b0};
        div_den   = {2'b00, max_rotor_speed};
      end
      ST_WT: begin
        div_start = wd != '0;
        div_num   = {wn_abs[31:0], 16'b0};
        div_den   = {1'b0, wd_abs[31:0]};
      end
      default: ;
    endcase
  end

  rtgi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign wmag = (div_quot > rtgi_pkg::DIV_NUM_W'(rtgi_pkg::W_LIM)) ? rtgi_pkg::W_LIM
                                                                    : div_quot[30:0];
  assign wval = wneg ? -$signed({1'b0, wmag}) : $signed({1'b0, wmag});

  // Memory addresses.
  logic [rtgi_pkg::HIDX_W-1:0] trow;
  logic [rtgi_pkg::SIDX_W-1:0] tcol;

  always_comb begin
    case (st)
      ST_SCAN: begin
        hg_addr = rtgi_pkg::HIDX_W'(sc);
        sg_addr = rtgi_pkg::SIDX_W'(sc);
      end
      ST_NB0: begin
        hg_addr = ki - rtgi_pkg::HIDX_W'(1);
        sg_addr = kj - rtgi_pkg::SIDX_W'(1);
      end
      default: begin
        hg_addr = ki;
        sg_addr = kj;
      end
    endcase
    trow     = tc[1] ? ki : ki - rtgi_pkg::HIDX_W'(1);
    tcol     = tc[0] ? kj : kj - rtgi_pkg::SIDX_W'(1);
    tab_addr = rtgi_pkg::TIDX_W'(trow) * rtgi_pkg::TIDX_W'(rtgi_pkg::SPEED_POINTS)
               + rtgi_pkg::TIDX_W'(tcol);
  end

  // Linear interpolation operands: corner pairs along the speed axis, then the
  // two partial results along the height axis.
  logic signed [31:0] lp, lq, lw;
  logic signed [32:0] ldiff;
  logic signed [31:0] lres;
  logic [17:0]        lclamp;

  always_comb begin
    case (lsub)
      2'd0: begin
        lp = lgain ? qf[0] : tf[0];
        lq = lgain ? qf[1] : tf[1];
        lw = wu;
      end
      2'd1: begin
        lp = lgain ? qf[2] : tf[2];
        lq = lgain ? qf[3] : tf[3];
        lw = wu;
      end
      default: begin
        lp = la;
        lq = lb;
        lw = wt;
      end
    endcase
    ldiff = {lq[31], lq} - {lp[31], lp};
    lres  = sat32($signed({{34{lp[31]}}, lp}) + (prod >>> 16));
    if (lres < $signed({14'b0, rtgi_pkg::G_MIN})) begin
      lclamp = rtgi_pkg::G_MIN;
    end else if (lres > $signed({14'b0, rtgi_pkg::G_MAX})) begin
      lclamp = rtgi_pkg::G_MAX;
    end else begin
      lclamp = lres[17:0];
    end
  end

  // Shared multiplier, product registered every cycle.
  logic signed [32:0] mul_a, mul_b;

  always_comb begin
    case (st)
      ST_RV: begin
        mul_a = {jv_r[31], jv_r};
        mul_b = {2'b00, slowdown_factor};
      end
      ST_LM: begin
        mul_a = {lw[31], lw};
        mul_b = ldiff;
      end
      ST_SQ: begin
        mul_a = {rv[31], rv};
        mul_b = {rv[31], rv};
      end
      ST_K: begin
        mul_a = osel ? {torque_constant[31], torque_constant}
                     : {thrust_constant[31], thrust_constant};
        mul_b = $signed({15'b0, osel ? gq : gt});
      end
      ST_M: begin
        mul_a = {kk[31], kk};
        mul_b = {sq[31], sq};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Final sign: thrust follows spin direction and velocity sign, torque only spin.
  logic signed [31:0] mres, mres_neg, sres;
  logic               dir_neg, dir_zero, s_neg, s_zero;

  always_comb begin
    mres     = sat32(prod >>> 16);
    mres_neg = (mres == 32'sh80000000) ? 32'sh7fffffff : -mres;
    dir_neg  = spin_direction[1];
    dir_zero = spin_direction == 2'sd0;
    s_neg    = osel ? dir_neg : (dir_neg ^ rv[31]);
    s_zero   = dir_zero || (!osel && rv == '0);
    sres     = s_zero ? '0 : (s_neg ? mres_neg : mres);
  end

  logic out_free, out_load;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  // A result word enters the output register from either finishing state.
  assign out_load = (st == ST_ACK || st == ST_DONE) && out_free;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (in_acc) st <= (in_cmd == rtgi_pkg::CMD_COMPUTE) ? ST_RV : ST_ACK;
        end
        ST_ACK: begin
          if (out_free) st <= ST_IDLE;
        end
        ST_RV:  st <= ST_RV2;
        ST_RV2: st <= ST_HR;
        ST_HR:  st <= hr_bypass ? ST_SR : ST_HRW;
        ST_HRW: if (div_done) st <= ST_SR;
        ST_SR: begin
          if (max_rotor_speed != '0) begin
            st <= ST_SRW;
          end else begin
            st <= (table_valid && !uw) ? ST_SCAN : ST_SQ;
          end
        end
        ST_SRW: if (div_done) st <= (table_valid && !uw) ? ST_SCAN : ST_SQ;
        ST_SCAN: if (scan_last && gsel) st <= ST_NB0;
        ST_NB0: st <= ST_NB1;
        ST_NB1: st <= ST_NB2;
        ST_NB2: st <= ST_WT;
        ST_WT: begin
          if (wd != '0) begin
            st <= ST_WTW;
          end else if (wsel) begin
            st <= ST_TRD;
          end
        end
        ST_WTW: if (div_done) st <= wsel ? ST_TRD : ST_WT;
        ST_TRD: if (tc == 3'd4) st <= ST_LM;
        ST_LM:  st <= ST_LA;
        ST_LA:  st <= (lgain && lsub == 2'd2) ? ST_SQ : ST_LM;
        ST_SQ:  st <= ST_SQ2;
        ST_SQ2: st <= ST_K;
        ST_K:   st <= ST_K2;
        ST_K2:  st <= ST_M;
        ST_M:   st <= ST_M2;
        ST_M2:  st <= osel ? ST_DONE : ST_K;
        ST_DONE: begin
          if (out_free) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_r <= in_cmd;
          jv_r  <= s_axis_tdata[69:38];
          h_r   <= s_axis_tdata[101:70];
        end
      end
      ST_ACK: begin
        if (out_free) begin
          o_thrust <= '0;
          o_torque <= '0;
          o_tg     <= '0;
          o_qg     <= '0;
          o_uw     <= 1'b0;
          o_load   <= cmd_r < rtgi_pkg::CMD_COMPUTE;
        end
      end
      ST_RV2: begin
        rv <= sat32(prod >>> 16);
        uw <= h_r <= 32'sd0;
      end
      ST_HR: if (hr_bypass) hr <= rtgi_pkg::Q_ONE[16:0];
      ST_HRW: if (div_done) hr <= div_quot[16:0];
      ST_SR: begin
        if (max_rotor_speed == '0) sr <= rtgi_pkg::G_MAX[16:0];
        gt    <= uw ? rtgi_pkg::G_WATER : rtgi_pkg::Q_ONE;
        gq    <= uw ? rtgi_pkg::G_WATER : rtgi_pkg::Q_ONE;
        gsel  <= 1'b0;
        sc    <= '0;
        chk   <= 1'b0;
        found <= 1'b0;
      end
      ST_SRW: begin
        if (div_done) begin
          sr <= (div_quot > rtgi_pkg::DIV_NUM_W'(rtgi_pkg::G_MAX)) ? rtgi_pkg::G_MAX[16:0]
                                                                   : div_quot[16:0];
        end
      end
      ST_SCAN: begin
        if (scan_last && !gsel) begin
          // Height cell found; restart the scan on the speed grid.
          ki    <= rtgi_pkg::HIDX_W'(k_cell);
          gsel  <= 1'b1;
          sc    <= '0;
          chk   <= 1'b0;
          found <= 1'b0;
        end else begin
          sc      <= sc + rtgi_pkg::SCAN_W'(1);
          chk     <= sc < n_sel;
          chk_idx <= sc;
          if (scan_hit) begin
            found <= 1'b1;
            fidx  <= chk_idx;
          end
          if (scan_last) kj <= rtgi_pkg::SIDX_W'(k_cell);
        end
      end
      ST_NB1: begin
        gh0 <= hg_q;
        gs0 <= sg_q;
      end
      ST_NB2: begin
        gh1  <= hg_q;
        gs1  <= sg_q;
        wsel <= 1'b0;
      end
      ST_WT: begin
        wneg <= wn[32] ^ wd[32];
        if (wd == '0) begin
          if (wsel) wu <= '0;
          else wt <= '0;
          wsel <= 1'b1;
          tc   <= '0;
        end
      end
      ST_WTW: begin
        if (div_done) begin
          if (wsel) wu <= wval;
          else wt <= wval;
          wsel <= 1'b1;
          tc   <= '0;
        end
      end
      ST_TRD: begin
        tc <= tc + 3'd1;
        if (tc != 3'd0) begin
          tf[2'(tc - 3'd1)] <= tt_q;
          qf[2'(tc - 3'd1)] <= tq_q;
        end
        lsub  <= '0;
        lgain <= 1'b0;
      end
      ST_LA: begin
        case (lsub)
          2'd0: la <= lres;
          2'd1: lb <= lres;
          default: begin
            if (lgain) gq <= lclamp;
            else gt <= lclamp;
          end
        endcase
        if (lsub == 2'd2) begin
          lsub  <= '0;
          lgain <= 1'b1;
        end else begin
          lsub <= lsub + 2'd1;
        end
      end
      ST_SQ2: begin
        sq   <= sat32(prod >>> 16);
        osel <= 1'b0;
      end
      ST_K2: kk <= sat32(prod >>> 16);
      ST_M2: begin
        if (osel) torque_r <= sres;
        else thrust_r <= sres;
        osel <= 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          o_thrust <= thrust_r;
          o_torque <= torque_r;
          o_tg     <= gt;
          o_qg     <= gq;
          o_uw     <= uw;
          o_load   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // The divider only runs while the sequencer waits on a quotient.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (st == ST_HRW || st == ST_SRW || st == ST_WTW))
    else $error("divider busy outside a divide wait state");

  // Table corners are only fetched from a clamped, nonzero cell.
  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    st == ST_TRD |-> (ki != '0 && kj != '0))
    else $error("table read with cell index zero");

  // Reported gains never exceed the upper clamp.
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[81:64] <= rtgi_pkg::G_MAX
                       && m_axis_tdata[99:82] <= rtgi_pkg::G_MAX))
    else $error("gain above upper clamp");

  // Underwater results carry the fixed water gain on both channels.
  a_water_gain: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[100]) |->
      (m_axis_tdata[81:64] == rtgi_pkg::G_WATER && m_axis_tdata[99:82] == rtgi_pkg::G_WATER))
    else $error("underwater result without water gain");
`endif

endmodule

// ===== design/rtgi_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on rtgi_pkg for operand widths.
module rtgi_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rtgi_pkg::DIV_NUM_W-1:0]   num,
  input  logic [rtgi_pkg::DIV_DEN_W-1:0]   den,
  output logic                             busy,
  output logic                             done,
  output logic [rtgi_pkg::DIV_NUM_W-1:0]   quot
);

  logic [rtgi_pkg::DIV_CNT_W-1:0] cnt;
  logic [rtgi_pkg::DIV_DEN_W-1:0] den_r;
  logic [rtgi_pkg::DIV_DEN_W-1:0] rem;
  logic [rtgi_pkg::DIV_DEN_W:0]   shifted;
  logic [rtgi_pkg::DIV_DEN_W+1:0] trial;
  logic                           fits;

  assign shifted = {rem, quot[rtgi_pkg::DIV_NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign fits    = !trial[rtgi_pkg::DIV_DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == rtgi_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= rtgi_pkg::DIV_CNT_W'(rtgi_pkg::DIV_NUM_W);
      quot  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      cnt  <= cnt - rtgi_pkg::DIV_CNT_W'(1);
      rem  <= fits ? trial[rtgi_pkg::DIV_DEN_W-1:0] : shifted[rtgi_pkg::DIV_DEN_W-1:0];
      quot <= {quot[rtgi_pkg::DIV_NUM_W-2:0], fits};
    end
  end

endmodule
